### hw/rtl/ppg_pkg.sv
// Package for the predator-prey grid cell update core: field structs,
// kind/status/opcode codes, register indexes and sequencer states. No dependencies.
package ppg_pkg;

    localparam int MaxRows   = 64;
    localparam int MaxCols   = 64;
    localparam int TimerBits = 8;
    localparam int RowBits   = $clog2(MaxRows);
    localparam int ColBits   = $clog2(MaxCols);
    localparam int AddrBits  = RowBits + ColBits;
    localparam int Cells     = MaxRows * MaxCols;
    localparam int TallyBits = 13;
    localparam int CellBits  = 2 + 2 * TimerBits;
    localparam logic [TallyBits-1:0] TallyMax = '1;
    localparam logic [TimerBits-1:0] TimerMax = '1;

    typedef enum logic [1:0] {
        K_WATER = 2'd0,
        K_FISH  = 2'd1,
        K_SHARK = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_INVALID = 3'd0,
        ST_MOVED   = 3'd1,
        ST_ATE     = 3'd2,
        ST_STUCK   = 3'd3,
        ST_DIED    = 3'd4,
        ST_ALIVE   = 3'd5,
        ST_DONE    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        OP_SHARK_MOVE  = 3'd0,
        OP_SHARK_AGE   = 3'd1,
        OP_FISH_MOVE   = 3'd2,
        OP_FISH_BREED  = 3'd3,
        OP_WRITE       = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        REG_ROWS   = 3'd0,
        REG_COLS   = 3'd1,
        REG_STARVE = 3'd2,
        REG_SBREED = 3'd3,
        REG_FBREED = 3'd4
    } t_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_CTR,
        S_RD_NB,
        S_RD_LAST,
        S_DECIDE,
        S_WR_DST,
        S_WR_SRC,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [RowBits-1:0]   row;
        logic [ColBits-1:0]   col;
        logic [1:0]           start_dir;
        logic [1:0]           cell_kind;
        logic [TimerBits-1:0] breed_age;
        logic [TimerBits-1:0] hunger_age;
    } t_req;

    typedef struct packed {
        logic [2:0]           status;
        logic [RowBits-1:0]   dest_row;
        logic [ColBits-1:0]   dest_col;
        logic [TallyBits-1:0] shark_total;
        logic [TallyBits-1:0] fish_total;
    } t_rsp;

endpackage

### hw/rtl/ppg_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ppg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // read one entry per cycle, and write it too when i_we is set (the read gives the old data)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hw/rtl/predator_prey_grid_cell_update_core.sv
// Predator-prey grid cell update core: top level with sequencer and grid memory.
// Depends on ppg_pkg and ppg_ram.
// Each request steps through a center read, four neighbour reads, last read capture,
// decide, two write slots and report, then o_done is high for one cycle. Busy stays
// high until the block is back in idle, so a new request waits until the last one is
// through, as the single memory port serves every read and write in turn.
// Reset: synchronous active-low; afterwards a clearing pass writes water to every cell
// while busy stays high. Results cannot be stalled.
module predator_prey_grid_cell_update_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ppg_pkg::t_req i_req,
    output logic          o_done,
    output ppg_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import ppg_pkg::*;

    t_state r_state, n_state;
    logic [AddrBits-1:0] r_cnt;
    logic [6:0] r_rows, r_cols;
    logic [7:0] r_starve, r_sbreed, r_fbreed;
    t_req r_req;
    logic [TallyBits-1:0] r_sharks, n_sharks, r_fish, n_fish;
    logic [CellBits-1:0] r_ctr;
    logic [1:0] r_nk [4];
    logic [1:0] r_ni;
    t_rsp r_rsp, n_rsp;
    logic r_done;

    // write plan set in decide state
    logic r_dwe, n_dwe, r_swe, n_swe;
    logic [AddrBits-1:0] r_daddr, n_daddr;
    logic [CellBits-1:0] r_dval, n_dval, r_sval, n_sval;

    // memory port
    logic mem_we;
    logic [AddrBits-1:0] mem_addr;
    logic [CellBits-1:0] mem_wdata, mem_rdata;

    ppg_ram #(.Width(CellBits), .Depth(Cells)) u_grid (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // effective sizes
    logic [6:0] eff_r, eff_c;
    always_comb begin
        eff_r = (r_rows == 7'd0) ? 7'd1 : (r_rows > 7'(MaxRows)) ? 7'(MaxRows) : r_rows;
        eff_c = (r_cols == 7'd0) ? 7'd1 : (r_cols > 7'(MaxCols)) ? 7'(MaxCols) : r_cols;
    end

    logic on_grid;
    assign on_grid = ({1'b0, r_req.row} < eff_r) && ({1'b0, r_req.col} < eff_c);

    // neighbour coordinates by direction
    logic [RowBits-1:0] nb_row [4];
    logic [ColBits-1:0] nb_col [4];
    always_comb begin
        logic [6:0] rp, cp;
        rp = {1'b0, r_req.row} + 7'd1;
        cp = {1'b0, r_req.col} + 7'd1;
        for (int d = 0; d < 4; d++) begin
            nb_row[d] = r_req.row;
            nb_col[d] = r_req.col;
        end
        nb_row[0] = (r_req.row == '0) ? RowBits'(eff_r - 7'd1) : r_req.row - 1'b1;
        nb_row[1] = (rp >= eff_r) ? '0 : rp[RowBits-1:0];
        nb_col[2] = (r_req.col == '0) ? ColBits'(eff_c - 7'd1) : r_req.col - 1'b1;
        nb_col[3] = (cp >= eff_c) ? '0 : cp[ColBits-1:0];
    end

    logic [AddrBits-1:0] ctr_addr;
    assign ctr_addr = {r_req.row, r_req.col};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:   if (r_cnt == '1) n_state = S_IDLE;
            S_IDLE:    if (start) n_state = S_RD_CTR;
            S_RD_CTR:  n_state = S_RD_NB;
            S_RD_NB:   if (r_ni == 2'd3) n_state = S_RD_LAST;
            S_RD_LAST: n_state = S_DECIDE;
            S_DECIDE:  n_state = S_WR_DST;
            S_WR_DST:  n_state = S_WR_SRC;
            S_WR_SRC:  n_state = S_REPORT;
            S_REPORT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_addr = ctr_addr;
        mem_wdata = r_dval;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_addr = r_cnt;
                mem_wdata = '0;
            end
            S_RD_CTR: mem_addr = ctr_addr;
            S_RD_NB:  mem_addr = {nb_row[r_ni], nb_col[r_ni]};
            S_WR_DST: begin
                mem_we = r_dwe;
                mem_addr = r_daddr;
                mem_wdata = r_dval;
            end
            S_WR_SRC: begin
                mem_we = r_swe;
                mem_addr = ctr_addr;
                mem_wdata = r_sval;
            end
            default: ;
        endcase
    end

    function automatic logic [TallyBits-1:0] inc_t(input logic [TallyBits-1:0] v);
        return (v == TallyMax) ? v : v + 1'b1;
    endfunction
    function automatic logic [TallyBits-1:0] dec_t(input logic [TallyBits-1:0] v);
        return (v == '0) ? v : v - 1'b1;
    endfunction
    function automatic logic [TimerBits-1:0] inc_tm(input logic [TimerBits-1:0] v);
        return (v == TimerMax) ? v : v + 1'b1;
    endfunction

    // decide: the rule for one cell
    always_comb begin
        logic [1:0] here;
        logic [TimerBits-1:0] bt, ht;
        logic nb_ok, fw_ok, ate, water;
        logic [1:0] fw_dir, lw_dir, ate_dir, d;
        logic [2:0] sharks;
        here = on_grid ? r_ctr[CellBits-1 -: 2] : K_BAD;
        bt = r_ctr[2*TimerBits-1 -: TimerBits];
        ht = r_ctr[TimerBits-1:0];
        nb_ok = 1'b1;
        for (int k = 0; k < 4; k++) if (r_nk[k] == K_BAD) nb_ok = 1'b0;
        fw_ok = 1'b0; fw_dir = '0; ate = 1'b0; ate_dir = '0;
        water = 1'b0; lw_dir = '0; sharks = '0;
        for (int i = 3; i >= 0; i--) begin
            d = r_req.start_dir + 2'(i);
            if (r_nk[d] == K_WATER) begin
                fw_ok = 1'b1; fw_dir = d;
            end
        end
        for (int i = 0; i < 4; i++) begin
            d = r_req.start_dir + 2'(i);
            if (!ate) begin
                if (r_nk[d] == K_FISH) begin
                    ate = 1'b1; ate_dir = d;
                end else if (r_nk[d] == K_SHARK) begin
                    sharks = sharks + 3'd1;
                end else if (r_nk[d] == K_WATER) begin
                    water = 1'b1; lw_dir = d;
                end
            end
        end
        n_sharks = r_sharks; n_fish = r_fish;
        n_dwe = 1'b0; n_swe = 1'b0;
        n_daddr = ctr_addr; n_dval = '0; n_sval = '0;
        n_rsp = '0;
        if (on_grid && r_req.opcode <= OP_WRITE) begin
            unique case (t_op'(r_req.opcode))
                OP_SHARK_MOVE: if (here == K_SHARK && nb_ok) begin
                    n_swe = 1'b1; n_dwe = 1'b1; n_dval = r_ctr;
                    if (ate) begin
                        n_fish = dec_t(r_fish);
                        n_rsp.status = ST_ATE;
                        n_rsp.dest_row = nb_row[ate_dir];
                        n_rsp.dest_col = nb_col[ate_dir];
                    end else if (sharks == 3'd4 || !water) begin
                        n_swe = 1'b0; n_dwe = 1'b0;
                        n_rsp.status = ST_STUCK;
                        n_rsp.dest_row = r_req.row;
                        n_rsp.dest_col = r_req.col;
                    end else begin
                        n_rsp.status = ST_MOVED;
                        n_rsp.dest_row = nb_row[lw_dir];
                        n_rsp.dest_col = nb_col[lw_dir];
                    end
                    n_daddr = {n_rsp.dest_row, n_rsp.dest_col};
                end
                OP_SHARK_AGE: if (here == K_SHARK) begin
                    n_rsp.dest_row = r_req.row;
                    n_rsp.dest_col = r_req.col;
                    n_swe = 1'b1;
                    if (ht == r_starve) begin
                        n_sval = '0;
                        n_sharks = dec_t(r_sharks);
                        n_rsp.status = ST_DIED;
                    end else if (bt < r_sbreed) begin
                        n_sval = {K_SHARK, inc_tm(bt), inc_tm(ht)};
                        n_rsp.status = ST_ALIVE;
                    end else if (nb_ok) begin
                        n_sval = {K_SHARK, {TimerBits{1'b0}}, inc_tm(ht)};
                        n_rsp.status = ST_ALIVE;
                        if (fw_ok) begin
                            n_dwe = 1'b1;
                            n_dval = {K_SHARK, {2*TimerBits{1'b0}}};
                            n_sharks = inc_t(r_sharks);
                            n_rsp.dest_row = nb_row[fw_dir];
                            n_rsp.dest_col = nb_col[fw_dir];
                        end
                    end else begin
                        // hunger advances even when the request fails
                        n_sval = {K_SHARK, bt, inc_tm(ht)};
                        n_rsp.dest_row = '0;
                        n_rsp.dest_col = '0;
                    end
                    n_daddr = {n_rsp.dest_row, n_rsp.dest_col};
                end
                OP_FISH_MOVE: if (here == K_FISH && nb_ok) begin
                    if (fw_ok) begin
                        n_swe = 1'b1; n_dwe = 1'b1; n_dval = r_ctr;
                        n_rsp.status = ST_MOVED;
                        n_rsp.dest_row = nb_row[fw_dir];
                        n_rsp.dest_col = nb_col[fw_dir];
                    end else begin
                        n_rsp.status = ST_STUCK;
                        n_rsp.dest_row = r_req.row;
                        n_rsp.dest_col = r_req.col;
                    end
                    n_daddr = {n_rsp.dest_row, n_rsp.dest_col};
                end
                OP_FISH_BREED: if (here == K_FISH) begin
                    n_rsp.dest_row = r_req.row;
                    n_rsp.dest_col = r_req.col;
                    if (bt < r_fbreed) begin
                        n_swe = 1'b1;
                        n_sval = {K_FISH, inc_tm(bt), ht};
                        n_rsp.status = ST_ALIVE;
                    end else if (nb_ok) begin
                        n_swe = 1'b1;
                        n_sval = {K_FISH, {TimerBits{1'b0}}, ht};
                        n_rsp.status = ST_ALIVE;
                        if (fw_ok) begin
                            n_dwe = 1'b1;
                            n_dval = {K_FISH, {2*TimerBits{1'b0}}};
                            n_fish = inc_t(r_fish);
                            n_rsp.dest_row = nb_row[fw_dir];
                            n_rsp.dest_col = nb_col[fw_dir];
                        end
                    end else begin
                        n_rsp.dest_row = '0;
                        n_rsp.dest_col = '0;
                    end
                    n_daddr = {n_rsp.dest_row, n_rsp.dest_col};
                end
                OP_WRITE: begin
                    if (here == K_SHARK) n_sharks = dec_t(n_sharks);
                    if (here == K_FISH)  n_fish = dec_t(n_fish);
                    if (r_req.cell_kind == K_SHARK) n_sharks = inc_t(n_sharks);
                    if (r_req.cell_kind == K_FISH)  n_fish = inc_t(n_fish);
                    n_swe = 1'b1;
                    n_sval = {r_req.cell_kind, r_req.breed_age, r_req.hunger_age};
                    n_rsp.status = ST_DONE;
                    n_rsp.dest_row = r_req.row;
                    n_rsp.dest_col = r_req.col;
                end
                default: ;
            endcase
        end
        n_rsp.shark_total = n_sharks;
        n_rsp.fish_total = n_fish;
    end

    // sequencer and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rows   <= 7'd64;
            r_cols   <= 7'd64;
            r_starve <= 8'd3;
            r_sbreed <= 8'd10;
            r_fbreed <= 8'd5;
            r_sharks <= '0;
            r_fish   <= '0;
            r_done   <= 1'b0;
            r_ni     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_REPORT);
            if (r_state == S_CLEAR) r_cnt <= r_cnt + 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ROWS:   r_rows   <= i_cfg_data[6:0];
                    REG_COLS:   r_cols   <= i_cfg_data[6:0];
                    REG_STARVE: r_starve <= i_cfg_data;
                    REG_SBREED: r_sbreed <= i_cfg_data;
                    REG_FBREED: r_fbreed <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_RD_NB) r_ni <= r_ni + 2'd1;
            else r_ni <= '0;
            if (r_state == S_DECIDE) begin
                r_sharks <= n_sharks;
                r_fish   <= n_fish;
            end
        end
    end

    // payload registers: capture reads and the write plan
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_req <= i_req;
        if (r_state == S_RD_NB && r_ni == 2'd0) r_ctr <= mem_rdata;
        if (r_state == S_RD_NB && r_ni != 2'd0) r_nk[r_ni - 2'd1] <= mem_rdata[CellBits-1 -: 2];
        // last neighbour read lands in S_RD_LAST, just after the read phase
        if (r_state == S_RD_LAST) r_nk[3] <= mem_rdata[CellBits-1 -: 2];
        if (r_state == S_DECIDE) begin
            r_dwe   <= n_dwe;
            r_swe   <= n_swe;
            r_daddr <= n_daddr;
            r_dval  <= n_dval;
            r_sval  <= n_sval;
            r_rsp   <= n_rsp;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // results appear in the cycle after report
    a_done_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_REPORT) else $error("done without report");
    a_busy_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> busy) else $error("request not held busy");
    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD_NB || r_state == S_RD_CTR) |-> !mem_we)
        else $error("memory write during read phase");
endmodule

### tb/ppg_grid_checker.sv
// Checker for the predator-prey grid cell update core: tracks the grid, timers,
// tallies and registers, predicts each result and compares it. Depends on ppg_pkg.
module ppg_grid_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  ppg_pkg::t_req i_req,
    input  logic          i_done,
    input  ppg_pkg::t_rsp i_rsp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppg_pkg::*;

    t_kind                kind_mem   [Cells];
    logic [TimerBits-1:0] breed_mem  [Cells];
    logic [TimerBits-1:0] hunger_mem [Cells];
    logic [TallyBits-1:0] shark_cnt, fish_cnt;
    logic [6:0]           rows_reg, cols_reg;
    logic [7:0]           starve_lim, sbreed_lim, fbreed_lim;
    t_rsp                 expected_rsp_q [$];
    int                   err_cnt;

    function automatic int rows_used();
        if (rows_reg == 0) return 1;
        if (rows_reg > MaxRows) return MaxRows;
        return rows_reg;
    endfunction

    function automatic int cols_used();
        if (cols_reg == 0) return 1;
        if (cols_reg > MaxCols) return MaxCols;
        return cols_reg;
    endfunction

    // Address of the neighbour in direction dir, wrapping on the rows/columns in use
    function automatic int nb_addr(int dir, int r, int c);
        int nr, nc, rr, cc;
        rr = rows_used();
        cc = cols_used();
        nr = r;
        nc = c;
        case (dir & 3)
            0: nr = (r + rr - 1) % rr;
            1: nr = (r + 1) % rr;
            2: nc = (c + cc - 1) % cc;
            default: nc = (c + 1) % cc;
        endcase
        return nr * MaxCols + nc;
    endfunction

    function automatic bit nbs_clean(int r, int c);
        for (int d = 0; d < 4; d++) begin
            if (kind_mem[nb_addr(d, r, c)] == K_BAD) return 0;
        end
        return 1;
    endfunction

    // First water in scan order, or -1
    function automatic int first_water(int dir, int r, int c);
        int a;
        for (int i = 0; i < 4; i++) begin
            a = nb_addr(dir + i, r, c);
            if (kind_mem[a] == K_WATER) return a;
        end
        return -1;
    endfunction

    function automatic void relocate(int from, int to, t_kind k);
        kind_mem[to]     = k;
        breed_mem[to]    = breed_mem[from];
        hunger_mem[to]   = hunger_mem[from];
        kind_mem[from]   = K_WATER;
        breed_mem[from]  = '0;
        hunger_mem[from] = '0;
    endfunction

    function automatic void place(int to, t_kind k);
        kind_mem[to]   = k;
        breed_mem[to]  = '0;
        hunger_mem[to] = '0;
    endfunction

    function automatic logic [TallyBits-1:0] cnt_up(logic [TallyBits-1:0] v);
        return (v == TallyMax) ? v : v + 1'b1;
    endfunction

    function automatic logic [TallyBits-1:0] cnt_dn(logic [TallyBits-1:0] v);
        return (v == 0) ? v : v - 1'b1;
    endfunction

    function automatic logic [TimerBits-1:0] timer_up(logic [TimerBits-1:0] v);
        return (v == TimerMax) ? v : v + 1'b1;
    endfunction

    // Apply one request to the tracked grid and return the result it should give
    function automatic t_rsp predict_cell_step(t_req q);
        t_rsp  p;
        int    r, c, dir, idx, a, w, sharks;
        t_kind here;
        bit    on_grid, ate, water;
        r = q.row;
        c = q.col;
        dir = q.start_dir;
        p = '0;
        p.status = ST_INVALID;
        on_grid = (r < rows_used()) && (c < cols_used());
        idx = r * MaxCols + c;
        here = on_grid ? kind_mem[idx] : K_BAD;
        w = -1;
        if (on_grid && q.opcode <= OP_WRITE) begin
            case (t_op'(q.opcode))
                OP_SHARK_MOVE: begin
                    if (here == K_SHARK && nbs_clean(r, c)) begin
                        sharks = 0;
                        ate = 0;
                        water = 0;
                        for (int i = 0; i < 4 && !ate; i++) begin
                            a = nb_addr(dir + i, r, c);
                            if (kind_mem[a] == K_FISH) begin
                                relocate(idx, a, K_SHARK);
                                fish_cnt = cnt_dn(fish_cnt);
                                p.status = ST_ATE;
                                w = a;
                                ate = 1;
                            end else if (kind_mem[a] == K_SHARK) begin
                                sharks++;
                            end else if (kind_mem[a] == K_WATER) begin
                                water = 1;
                                w = a;
                            end
                        end
                        if (!ate) begin
                            if (sharks == 4 || !water) begin
                                p.status = ST_STUCK;
                                w = idx;
                            end else begin
                                relocate(idx, w, K_SHARK);
                                p.status = ST_MOVED;
                            end
                        end
                    end
                end
                OP_SHARK_AGE: begin
                    if (here == K_SHARK) begin
                        if (hunger_mem[idx] == starve_lim) begin
                            place(idx, K_WATER);
                            shark_cnt = cnt_dn(shark_cnt);
                            p.status = ST_DIED;
                            w = idx;
                        end else begin
                            // hunger advances even if the breed check then fails
                            hunger_mem[idx] = timer_up(hunger_mem[idx]);
                            if (breed_mem[idx] < sbreed_lim) begin
                                breed_mem[idx] = timer_up(breed_mem[idx]);
                                p.status = ST_ALIVE;
                                w = idx;
                            end else if (nbs_clean(r, c)) begin
                                breed_mem[idx] = '0;
                                p.status = ST_ALIVE;
                                w = first_water(dir, r, c);
                                if (w >= 0) begin
                                    place(w, K_SHARK);
                                    shark_cnt = cnt_up(shark_cnt);
                                end else begin
                                    w = idx;
                                end
                            end
                        end
                    end
                end
                OP_FISH_MOVE: begin
                    if (here == K_FISH && nbs_clean(r, c)) begin
                        w = first_water(dir, r, c);
                        if (w >= 0) begin
                            relocate(idx, w, K_FISH);
                            p.status = ST_MOVED;
                        end else begin
                            p.status = ST_STUCK;
                            w = idx;
                        end
                    end
                end
                OP_FISH_BREED: begin
                    if (here == K_FISH) begin
                        if (breed_mem[idx] < fbreed_lim) begin
                            breed_mem[idx] = timer_up(breed_mem[idx]);
                            p.status = ST_ALIVE;
                            w = idx;
                        end else if (nbs_clean(r, c)) begin
                            breed_mem[idx] = '0;
                            p.status = ST_ALIVE;
                            w = first_water(dir, r, c);
                            if (w >= 0) begin
                                place(w, K_FISH);
                                fish_cnt = cnt_up(fish_cnt);
                            end else begin
                                w = idx;
                            end
                        end
                    end
                end
                default: begin
                    // write: retire the old occupant, count the new one
                    if (here == K_SHARK) shark_cnt = cnt_dn(shark_cnt);
                    if (here == K_FISH) fish_cnt = cnt_dn(fish_cnt);
                    if (q.cell_kind == K_SHARK) shark_cnt = cnt_up(shark_cnt);
                    if (q.cell_kind == K_FISH) fish_cnt = cnt_up(fish_cnt);
                    kind_mem[idx]   = t_kind'(q.cell_kind);
                    breed_mem[idx]  = q.breed_age;
                    hunger_mem[idx] = q.hunger_age;
                    p.status = ST_DONE;
                    w = idx;
                end
            endcase
        end
        if (w >= 0) begin
            p.dest_row = RowBits'(w / MaxCols);
            p.dest_col = ColBits'(w % MaxCols);
        end
        p.shark_total = shark_cnt;
        p.fish_total = fish_cnt;
        return p;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Track registers and requests, check each result against the oldest prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < Cells; i++) begin
                place(i, K_WATER);
            end
            shark_cnt = '0;
            fish_cnt = '0;
            rows_reg = 7'd64;
            cols_reg = 7'd64;
            starve_lim = 8'd3;
            sbreed_lim = 8'd10;
            fbreed_lim = 8'd5;
            expected_rsp_q.delete();
            err_cnt = 0;
        end else begin
            if (i_done) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("result with no request pending", i_rsp.status, -1);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.status != want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.dest_row != want.dest_row)
                        report_mismatch("dest_row", i_rsp.dest_row, want.dest_row);
                    if (i_rsp.dest_col != want.dest_col)
                        report_mismatch("dest_col", i_rsp.dest_col, want.dest_col);
                    if (i_rsp.shark_total != want.shark_total)
                        report_mismatch("shark_total", i_rsp.shark_total, want.shark_total);
                    if (i_rsp.fish_total != want.fish_total)
                        report_mismatch("fish_total", i_rsp.fish_total, want.fish_total);
                end
            end
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_ROWS:   rows_reg = i_cfg_data[6:0];
                    REG_COLS:   cols_reg = i_cfg_data[6:0];
                    REG_STARVE: starve_lim = i_cfg_data;
                    REG_SBREED: sbreed_lim = i_cfg_data;
                    REG_FBREED: fbreed_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) expected_rsp_q.push_back(predict_cell_step(i_req));
        end
        o_pending <= expected_rsp_q.size();
        o_errors <= err_cnt;
    end

endmodule

### tb/predator_prey_grid_cell_update_core_test.sv
// Top of the predator-prey grid cell update core test: clock, reset, requests,
// register phases and verdict. Depends on ppg_pkg, the core and ppg_grid_checker.
module predator_prey_grid_cell_update_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ppg_pkg::*;

    localparam int IdleLimit = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       o_done;
    t_rsp       o_rsp;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = REG_ROWS;
    logic [7:0] i_cfg_data = '0;
    int         errors, pending;
    int         idle_cycles = 0;
    int         rows_now = 64, cols_now = 64;
    bit         no_gaps = 0;

    predator_prey_grid_cell_update_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ppg_grid_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_req      (i_req),
        .i_done     (o_done),
        .i_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_req mk(logic [2:0] op, int r, int c, int dir, t_kind k,
                                int b, int h);
        t_req q;
        q.opcode = op;
        q.row = RowBits'(r);
        q.col = ColBits'(c);
        q.start_dir = 2'(dir);
        q.cell_kind = k;
        q.breed_age = TimerBits'(b);
        q.hunger_age = TimerBits'(h);
        return q;
    endfunction

    // Present a request, hold it until accepted, then maybe pause
    task automatic issue(t_req q);
        int gap, sel;
        i_req <= q;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sel = $urandom_range(0, 99);
        if (no_gaps) gap = 0;
        else if (sel < 40) gap = 0;
        else if (sel < 92) gap = $urandom_range(1, 4);
        else gap = $urandom_range(15, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain every pending request, then let the block finish its sequence
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic configure(int r, int c, int st, int sb, int fb);
        t_reg idx [5] = '{REG_ROWS, REG_COLS, REG_STARVE, REG_SBREED, REG_FBREED};
        int   val [5];
        val = '{r, c, st, sb, fb};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= 8'(val[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        rows_now = (r == 0) ? 1 : (r > MaxRows ? MaxRows : r);
        cols_now = (c == 0) ? 1 : (c > MaxCols ? MaxCols : c);
    endtask

    initial begin
        int ph_rows [8] = '{4, 0, 2, 127, 8, 3, 64, 5};
        int ph_cols [8] = '{4, 6, 2, 3, 8, 64, 64, 0};
        int ph_st   [8] = '{3, 0, 255, 2, 5, 1, 3, 4};
        int ph_sb   [8] = '{4, 0, 255, 3, 6, 2, 10, 1};
        int ph_fb   [8] = '{2, 0, 255, 1, 4, 3, 5, 0};
        int sel, r, c, b, h;
        logic [2:0] op;
        t_kind k;

        // Reset, then wait out the clearing pass
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Directed: eat, breed with saturated timers, bad neighbours, death, stuck fish
        issue(mk(OP_WRITE, 0, 1, 0, K_FISH, 0, 0));
        issue(mk(OP_WRITE, 0, 0, 0, K_SHARK, 255, 255));
        issue(mk(OP_SHARK_MOVE, 0, 0, 3, K_WATER, 0, 0));
        issue(mk(OP_SHARK_AGE, 0, 1, 0, K_WATER, 0, 0));
        issue(mk(OP_WRITE, 5, 5, 0, K_BAD, 255, 255));
        issue(mk(OP_WRITE, 5, 6, 0, K_SHARK, 0, 0));
        issue(mk(OP_SHARK_MOVE, 5, 6, 1, K_WATER, 0, 0));
        issue(mk(OP_SHARK_AGE, 5, 6, 2, K_WATER, 0, 0));
        issue(mk(OP_WRITE, 5, 6, 0, K_SHARK, 10, 0));
        issue(mk(OP_SHARK_AGE, 5, 6, 2, K_WATER, 0, 0));
        issue(mk(3'd5, 0, 0, 0, K_WATER, 0, 0));
        issue(mk(3'd7, 63, 63, 3, K_BAD, 255, 255));
        issue(mk(OP_FISH_MOVE, 20, 20, 0, K_WATER, 0, 0));
        issue(mk(OP_WRITE, 10, 10, 0, K_FISH, 5, 7));
        issue(mk(OP_WRITE, 9, 10, 0, K_SHARK, 0, 3));
        issue(mk(OP_WRITE, 11, 10, 0, K_SHARK, 0, 0));
        issue(mk(OP_WRITE, 10, 9, 0, K_SHARK, 0, 0));
        issue(mk(OP_WRITE, 10, 11, 0, K_SHARK, 0, 0));
        issue(mk(OP_FISH_MOVE, 10, 10, 2, K_WATER, 0, 0));
        issue(mk(OP_FISH_BREED, 10, 10, 1, K_WATER, 0, 0));
        issue(mk(OP_SHARK_AGE, 9, 10, 0, K_WATER, 0, 0));
        issue(mk(OP_SHARK_MOVE, 11, 10, 0, K_WATER, 0, 0));
        issue(mk(OP_WRITE, 30, 30, 0, K_FISH, 5, 0));
        issue(mk(OP_FISH_BREED, 30, 30, 3, K_WATER, 0, 0));
        issue(mk(OP_FISH_MOVE, 30, 30, 0, K_WATER, 0, 0));

        // Random phases, each with its own grid size and limits
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 7) configure($urandom_range(1, 64), $urandom_range(1, 64),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255));
            else configure(ph_rows[ph], ph_cols[ph], ph_st[ph], ph_sb[ph], ph_fb[ph]);
            for (int n = 0; n < 205; n++) begin
                no_gaps = (n >= 80 && n < 120);
                sel = $urandom_range(0, 99);
                if (sel < 28) op = OP_WRITE;
                else if (sel < 43) op = OP_SHARK_MOVE;
                else if (sel < 60) op = OP_SHARK_AGE;
                else if (sel < 75) op = OP_FISH_MOVE;
                else if (sel < 92) op = OP_FISH_BREED;
                else if (sel < 95) op = 3'($urandom_range(5, 7));
                else op = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0) begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                end else begin
                    r = $urandom_range(0, rows_now - 1);
                    c = $urandom_range(0, cols_now - 1);
                end
                sel = $urandom_range(0, 99);
                if (sel < 32) k = K_WATER;
                else if (sel < 64) k = K_FISH;
                else if (sel < 96) k = K_SHARK;
                else k = K_BAD;
                b = $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 255);
                h = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 255);
                issue(mk(op, r, c, $urandom_range(0, 3), k, b, h));
            end
        end

        drain();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
